FILE: hdl/kfss_pkg.sv
package kfss_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);

    localparam logic [15:0] SpeedMin = 16'd205;
    localparam logic [15:0] SpeedMax = 16'd40960;
    localparam logic [15:0] SpeedOne = 16'd4096;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    // clamp a requested speed into the legal Q4.12 range
    function automatic logic [15:0] clamp_speed(input logic [15:0] v);
        logic [15:0] r;
        r = v;
        if (v < SpeedMin) r = SpeedMin;
        if (v > SpeedMax) r = SpeedMax;
        return r;
    endfunction

endpackage

FILE: hdl/keyframe_smoothstep_curve_table.sv
// Keyframe speed table, smoothstep blend; one item at a time. An add scans for its slot,
// shifts later points up and writes the point; a remove shifts later points down. A query
// at or before the first point, or at or after the last, gives that point's speed, else it
// blends to the first later point (48-step divide, three multiplies). The next input is
// taken in the cycle after the result beat; i_stall holds the block.
// Reset (synchronous, active low): entry 0 written with the single point (0, 1.0).
module keyframe_smoothstep_curve_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_mode,
    input  logic [31:0]               i_time_q16,
    input  logic [15:0]               i_speed_in,
    input  logic [5:0]                i_point_index,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [15:0]               o_speed_out,
    output logic [1:0]                o_status,
    output logic [6:0]                o_point_total
);
    import kfss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
        S_SEG_RD, S_SEG_LD, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_DONE
    } t_state;

    t_state            r_state;
    t_mode             r_mode;
    logic [31:0]       r_time;
    logic [15:0]       r_speed;
    logic [CntW-1:0]   r_count;
    logic [15:0]       r_last_clamp;
    logic [CntW-1:0]   r_ptr;
    logic [CntW-1:0]   r_pos;
    logic [1:0]        r_status;
    logic              r_out_valid;
    logic [15:0]       r_out_speed;

    // table memory: one read and one write port, read data registered
    logic [47:0]       r_mem [MaxPoints];
    logic [47:0]       r_rd;
    logic [IdxW-1:0]   w_rd_addr;
    logic              w_wr_en;
    logic [IdxW-1:0]   w_wr_addr;
    logic [47:0]       w_wr_data;

    // segment operands and shared arithmetic
    logic [31:0]       r_t0;
    logic [15:0]       r_s0;
    logic [31:0]       r_span;
    logic [47:0]       r_rem;
    logic [47:0]       r_num;
    logic [16:0]       r_u;
    logic [5:0]        r_bit;
    logic [31:0]       r_acc;
    logic [16:0]       r_ma;
    logic [17:0]       r_mb;
    logic [34:0]       w_prod;
    logic [48:0]       w_trial;

    assign w_prod  = r_ma * r_mb;
    assign w_trial = {r_rem, r_num[47]} - {17'd0, r_span};

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        r_rd <= r_mem[w_rd_addr];
    end

    // memory address and write control per state
    always_comb begin
        w_rd_addr = r_ptr[IdxW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_ptr[IdxW-1:0];
        w_wr_data = r_rd;
        case (r_state)
            S_SHIFT_RD: begin
                if (r_mode == MODE_ADD) w_rd_addr = IdxW'(r_ptr - 1'b1);
            end
            S_SHIFT_WR: begin
                w_wr_en = 1'b1;
                if (r_mode == MODE_ADD) w_wr_addr = r_ptr[IdxW-1:0];
                else w_wr_addr = IdxW'(r_ptr - 1'b1);
            end
            S_PUT: begin
                w_wr_en   = (r_mode == MODE_ADD) || (r_mode == MODE_CLEAR);
                w_wr_addr = (r_mode == MODE_ADD) ? r_pos[IdxW-1:0] : '0;
                w_wr_data = (r_mode == MODE_ADD) ? {r_time, r_speed} : {32'd0, SpeedOne};
            end
            default: ;
        endcase
        // reset loads the default point
        if (!i_rst_n) begin
            w_wr_en   = 1'b1;
            w_wr_addr = '0;
            w_wr_data = {32'd0, SpeedOne};
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_speed_out   = r_out_speed;
    assign o_status      = r_status;
    assign o_point_total = 7'(r_count);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= CntW'(1);
            r_last_clamp <= SpeedOne;
            r_out_valid  <= 1'b0;
            r_ptr        <= '0;
            r_mode       <= MODE_CLEAR;
            r_bit        <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode    <= t_mode'(i_mode);
                        r_time    <= i_time_q16;
                        r_speed   <= clamp_speed(i_speed_in);
                        case (t_mode'(i_mode))
                            MODE_ADD: begin
                                r_last_clamp <= clamp_speed(i_speed_in);
                                r_out_speed  <= clamp_speed(i_speed_in);
                                r_ptr        <= '0;
                                if (r_count == CntW'(MaxPoints)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_SCAN_RD;
                                end
                            end
                            MODE_REMOVE: begin
                                r_out_speed <= r_last_clamp;
                                if ({1'b0, i_point_index} >= r_count || r_count == CntW'(1))
                                begin
                                    r_status <= ST_REFUSED;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_ptr    <= CntW'(i_point_index) + 1'b1;
                                    r_state  <= S_SHIFT_RD;
                                end
                            end
                            MODE_CLEAR: begin
                                r_out_speed <= r_last_clamp;
                                r_status    <= ST_OK;
                                r_count     <= CntW'(1);
                                r_state     <= S_PUT;
                            end
                            default: begin
                                r_out_speed <= r_last_clamp;
                                r_status    <= ST_OK;
                                r_ptr       <= '0;
                                r_state     <= S_SCAN_RD;
                            end
                        endcase
                    end
                end
                // scan for first entry with time >= t (add) or time > t (query)
                S_SCAN_RD: begin
                    if (r_ptr == r_count) begin
                        r_pos <= r_ptr;
                        if (r_mode == MODE_ADD) begin
                            r_ptr   <= r_count;
                            r_state <= S_PUT;
                        end else begin
                            r_ptr   <= r_count - 1'b1;
                            r_state <= S_SEG_RD;
                        end
                    end else begin
                        r_state <= S_SCAN_CMP;
                    end
                end
                // a query at or before the first point holds the first speed
                S_SCAN_CMP: begin
                    if ((r_mode == MODE_ADD && r_rd[47:16] >= r_time) ||
                        (r_mode == MODE_QUERY && (r_rd[47:16] > r_time ||
                         (r_ptr == '0 && r_rd[47:16] >= r_time)))) begin
                        r_pos <= r_ptr;
                        if (r_mode == MODE_ADD) begin
                            r_ptr   <= r_count;
                            r_state <= (r_count == r_ptr) ? S_PUT : S_SHIFT_RD;
                        end else if (r_ptr == '0) begin
                            r_out_speed <= r_rd[15:0];
                            r_state     <= S_DONE;
                        end else begin
                            r_t0    <= r_rd[47:16];
                            r_s0    <= r_rd[15:0];
                            r_ptr   <= r_ptr - 1'b1;
                            r_state <= S_SEG_RD;
                        end
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                // shift: add moves [ptr-1] to [ptr] downward; remove moves [ptr] to [ptr-1]
                S_SHIFT_RD: begin
                    if (r_mode == MODE_ADD) begin
                        if (r_ptr == r_pos) r_state <= S_PUT;
                        else r_state <= S_SHIFT_WR;
                    end else begin
                        if (r_ptr == r_count) begin
                            r_count <= r_count - 1'b1;
                            r_state <= S_DONE;
                        end else r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    if (r_mode == MODE_ADD) r_ptr <= r_ptr - 1'b1;
                    else r_ptr <= r_ptr + 1'b1;
                    r_state <= S_SHIFT_RD;
                end
                S_PUT: begin
                    if (r_mode == MODE_ADD) r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                // query segment: last point, or left point of segment
                S_SEG_RD: r_state <= S_SEG_LD;
                S_SEG_LD: begin
                    if (r_pos == r_count) begin
                        r_out_speed <= r_rd[15:0];
                        r_state     <= S_DONE;
                    end else begin
                        // r_t0/r_s0 hold the right point; swap in the left point
                        r_span  <= r_t0 - r_rd[47:16];
                        r_num   <= {r_time - r_rd[47:16], 16'd0};
                        r_t0    <= r_rd[47:16];
                        r_mb    <= {2'd0, r_s0};
                        r_s0    <= r_rd[15:0];
                        r_rem   <= '0;
                        r_bit   <= 6'd48;
                        r_state <= S_DIV;
                    end
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (!w_trial[48]) r_rem <= w_trial[47:0];
                    else r_rem <= {r_rem[46:0], r_num[47]};
                    r_num <= {r_num[46:0], !w_trial[48]};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 6'd1) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_u  <= (r_num[47:16] != '0) ? 17'd65535 : {1'b0, r_num[15:0]};
                    r_ma <= (r_num[47:16] != '0) ? 17'd65535 : {1'b0, r_num[15:0]};
                    r_acc <= {r_mb[15:0], 16'd0};
                    r_mb <= (r_num[47:16] != '0) ? 18'd65535 : {2'd0, r_num[15:0]};
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // u2 = u*u >> 16, then times (3 - 2u)
                    r_ma    <= w_prod[32:16];
                    r_mb    <= 18'(18'd196608 - {r_u, 1'b0});
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_ma <= w_prod[32:16];
                    r_mb <= (r_acc[31:16] >= r_s0) ? {2'd0, r_acc[31:16] - r_s0}
                                                   : {2'd0, r_s0 - r_acc[31:16]};
                    r_state <= S_DONE;
                    r_bit   <= 6'd63;
                end
                S_DONE: begin
                    if (r_mode == MODE_QUERY && r_bit == 6'd63) begin
                        r_bit <= '0;
                        r_out_speed <= (r_acc[31:16] >= r_s0)
                            ? 16'(r_s0 + w_prod[31:16]) : 16'(r_s0 - w_prod[31:16]);
                    end else if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end else if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CntW'(1)) && (r_count <= CntW'(MaxPoints)))
        else $error("point count out of range");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accepting while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_speed_out)))
        else $error("result dropped under stall");

endmodule
